### hdl/rrts_pkg.sv
// Shared types, constants and helpers of the round-robin thread scheduler.
package rrts_pkg;

   localparam int MAX_THREADS = 64;
   localparam int MAX_CPUS    = 8;

   localparam int FUNC_W      = 2;
   localparam int THREAD_W    = 7;
   localparam int CODE_W      = 4;
   localparam int CPU_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int OUTCOME_W   = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int CPU_COUNT_W = 4;

   localparam int SLOT_W  = $clog2(MAX_THREADS);
   localparam int COUNT_W = SLOT_W + 1;
   localparam int OWNER_W = CPU_W + 1;

   localparam logic [THREAD_W-1:0]    NO_THREAD       = THREAD_W'(MAX_THREADS);
   localparam logic [OWNER_W-1:0]     OWNER_NONE      = '0;
   localparam logic [CPU_COUNT_W-1:0] CPU_COUNT_RESET = CPU_COUNT_W'(1);
   localparam logic [CODE_W-1:0]      RUNNABLE_RESET  = CODE_W'(1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE     = 2'd0,
      FUNC_DESTROY    = 2'd1,
      FUNC_SET_STATE  = 2'd2,
      FUNC_RESCHEDULE = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_BAD_CPU = 2'd2
   } status_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_IDLE   = 2'd0,
      OUTCOME_SAME   = 2'd1,
      OUTCOME_SWITCH = 2'd2
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CPU_COUNT = 1'b0,
      CSR_RUNNABLE  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_RELEASE,
      S_CREATE,
      S_SCAN,
      S_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic latch_item;
      logic do_destroy;
      logic do_set_state;
      logic rel_read;
      logic rel_write;
      logic create_init;
      logic create_next;
      logic create_take;
      logic res_ok;
      logic res_full;
      logic res_bad_cpu;
      logic scan_init;
      logic scan_step;
      logic scan_pick;
      logic scan_miss;
      logic emit;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     tid_in_range;
      logic     tid_valid;
      logic     cpu_ok;
      logic     release_needed;
      logic     owner_match;
      logic     create_free;
      logic     create_last;
      logic     scan_hit;
      logic     scan_exhausted;
      logic     out_free;
   } sts_type;

   // Circular successor of a slot number.
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(MAX_THREADS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

endpackage

### hdl/rrts_req_if.sv
// Request channel of the scheduler: handshake plus one operation beat.
interface rrts_req_if import rrts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [THREAD_W-1:0] slot_id;
   logic [CODE_W-1:0]   state_code;
   logic [CPU_W-1:0]    cpu;
   logic                keep_owner;

   modport source (output valid, func, slot_id, state_code, cpu, keep_owner, input ready);
   modport sink   (input valid, func, slot_id, state_code, cpu, keep_owner, output ready);
endinterface

### hdl/rrts_rsp_if.sv
// Response channel of the scheduler: handshake plus one result beat.
interface rrts_rsp_if import rrts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [THREAD_W-1:0]  result_thread;
   logic [OUTCOME_W-1:0] outcome;

   modport source (output valid, status, result_thread, outcome, input ready);
   modport sink   (input valid, status, result_thread, outcome, output ready);
endinterface

### hdl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### hdl/rrts_datapath.sv
// Scheduler datapath: thread table, processor table, pick pointer, scan and result registers.
module rrts_datapath import rrts_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [THREAD_W-1:0]    req_slot_id,
   input  logic [CODE_W-1:0]      req_state_code,
   input  logic [CPU_W-1:0]       req_cpu,
   input  logic                   req_keep_owner,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [THREAD_W-1:0]    rsp_result_thread,
   output logic [OUTCOME_W-1:0]   rsp_outcome,
   input  cmd_type                cmd,
   output sts_type                sts
);

   logic [CPU_COUNT_W-1:0] cpu_count_ff;
   logic [CODE_W-1:0]      runnable_ff;
   logic [MAX_THREADS-1:0] slot_valid_ff;
   logic [THREAD_W-1:0]    cpu_current_ff [MAX_CPUS];
   logic [SLOT_W-1:0]      pick_ptr_ff;

   func_type               func_ff;
   logic [THREAD_W-1:0]    tid_ff;
   logic [CODE_W-1:0]      code_ff;
   logic [CPU_W-1:0]       cpu_ff;
   logic                   keep_ff;

   logic [SLOT_W-1:0]      create_idx_ff;
   logic [SLOT_W-1:0]      scan_addr_ff;
   logic [COUNT_W-1:0]     issued_ff;
   logic                   chk_v_ff;
   logic [SLOT_W-1:0]      chk_addr_ff;

   status_type             res_status_ff;
   logic [THREAD_W-1:0]    res_thread_ff;
   outcome_type            res_outcome_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [THREAD_W-1:0]    rsp_thread_ff;
   outcome_type            rsp_outcome_ff;

   logic [THREAD_W-1:0]    cur;
   logic [SLOT_W-1:0]      cur_slot;
   logic                   cur_in_range;
   logic [SLOT_W-1:0]      tid_slot;
   logic [THREAD_W-1:0]    chk_thread;

   logic                   state_we;
   logic [SLOT_W-1:0]      state_waddr;
   logic [CODE_W-1:0]      state_wdata;
   logic [CODE_W-1:0]      state_rd;
   logic                   owner_we;
   logic [SLOT_W-1:0]      owner_waddr;
   logic [OWNER_W-1:0]     owner_wdata;
   logic [SLOT_W-1:0]      owner_raddr;
   logic [OWNER_W-1:0]     owner_rd;
   logic                   scan_hit;
   logic                   out_free;

   assign cur          = cpu_current_ff[cpu_ff];
   assign cur_slot     = cur[SLOT_W-1:0];
   assign cur_in_range = cur < NO_THREAD;
   assign tid_slot     = tid_ff[SLOT_W-1:0];
   assign chk_thread   = THREAD_W'(chk_addr_ff);

   // Table memories: state code and owner ({owned, cpu}) per slot.
   always_comb begin
      state_we    = cmd.do_set_state | cmd.create_take;
      state_waddr = cmd.create_take ? create_idx_ff : tid_slot;
      state_wdata = cmd.create_take ? '0 : code_ff;

      owner_we    = cmd.rel_write | cmd.create_take | cmd.scan_pick;
      owner_waddr = chk_addr_ff;
      owner_wdata = {1'b1, cpu_ff};
      if (cmd.rel_write) begin
         owner_waddr = cur_slot;
         owner_wdata = OWNER_NONE;
      end else if (cmd.create_take) begin
         owner_waddr = create_idx_ff;
         owner_wdata = OWNER_NONE;
      end
      owner_raddr = cmd.rel_read ? cur_slot : scan_addr_ff;
   end

   rrts_ram #(.WIDTH(CODE_W), .DEPTH(MAX_THREADS)) u_state_ram (
      .clock      (clock),
      .write_en   (state_we),
      .write_addr (state_waddr),
      .write_data (state_wdata),
      .read_addr  (scan_addr_ff),
      .read_data  (state_rd)
   );

   rrts_ram #(.WIDTH(OWNER_W), .DEPTH(MAX_THREADS)) u_owner_ram (
      .clock      (clock),
      .write_en   (owner_we),
      .write_addr (owner_waddr),
      .write_data (owner_wdata),
      .read_addr  (owner_raddr),
      .read_data  (owner_rd)
   );

   assign scan_hit = chk_v_ff && slot_valid_ff[chk_addr_ff] &&
                     (state_rd == runnable_ff) && !owner_rd[OWNER_W-1];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.func           = func_ff;
      sts.tid_in_range   = tid_ff < NO_THREAD;
      sts.tid_valid      = slot_valid_ff[tid_slot];
      sts.cpu_ok         = ({1'b0, cpu_ff} < cpu_count_ff) &&
                           ({1'b0, cpu_ff} < CPU_COUNT_W'(MAX_CPUS));
      sts.release_needed = !keep_ff && cur_in_range && slot_valid_ff[cur_slot];
      sts.owner_match    = owner_rd[OWNER_W-1] && (owner_rd[CPU_W-1:0] == cpu_ff);
      sts.create_free    = !slot_valid_ff[create_idx_ff];
      sts.create_last    = create_idx_ff == SLOT_W'(MAX_THREADS - 1);
      sts.scan_hit       = scan_hit;
      sts.scan_exhausted = issued_ff == COUNT_W'(MAX_THREADS);
      sts.out_free       = out_free;
   end

   // Control state: configuration, slot valid bits, processor table, pointer, beat valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_count_ff  <= CPU_COUNT_RESET;
         runnable_ff   <= RUNNABLE_RESET;
         slot_valid_ff <= '0;
         for (int i = 0; i < MAX_CPUS; i++) begin
            cpu_current_ff[i] <= NO_THREAD;
         end
         pick_ptr_ff   <= '0;
         chk_v_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_CPU_COUNT: cpu_count_ff <= CPU_COUNT_W'(csr_wdata);
               CSR_RUNNABLE:  runnable_ff  <= CODE_W'(csr_wdata);
            endcase
         end
         if (cmd.do_destroy) begin
            slot_valid_ff[tid_slot] <= 1'b0;
         end
         if (cmd.create_take) begin
            slot_valid_ff[create_idx_ff] <= 1'b1;
         end
         if (cmd.scan_init) begin
            chk_v_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_v_ff <= 1'b1;
         end
         if (cmd.scan_pick) begin
            cpu_current_ff[cpu_ff] <= chk_thread;
            pick_ptr_ff            <= next_slot(chk_addr_ff);
         end
         if (cmd.scan_miss) begin
            // Every slot was examined once without a hit.
            cpu_current_ff[cpu_ff] <= NO_THREAD;
            pick_ptr_ff            <= next_slot(pick_ptr_ff);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         func_ff <= func_type'(req_func);
         tid_ff  <= req_slot_id;
         code_ff <= req_state_code;
         cpu_ff  <= req_cpu;
         keep_ff <= req_keep_owner;
      end
      if (cmd.create_init) begin
         create_idx_ff <= '0;
      end else if (cmd.create_next) begin
         create_idx_ff <= create_idx_ff + SLOT_W'(1);
      end
      if (cmd.scan_init) begin
         scan_addr_ff <= pick_ptr_ff;
         issued_ff    <= '0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= next_slot(scan_addr_ff);
         issued_ff    <= issued_ff + COUNT_W'(1);
         chk_addr_ff  <= scan_addr_ff;
      end
      if (cmd.res_ok) begin
         res_status_ff  <= STATUS_OK;
         res_thread_ff  <= NO_THREAD;
         res_outcome_ff <= OUTCOME_IDLE;
      end
      if (cmd.res_full) begin
         res_status_ff  <= STATUS_FULL;
         res_thread_ff  <= NO_THREAD;
         res_outcome_ff <= OUTCOME_IDLE;
      end
      if (cmd.res_bad_cpu) begin
         res_status_ff  <= STATUS_BAD_CPU;
         res_thread_ff  <= NO_THREAD;
         res_outcome_ff <= OUTCOME_IDLE;
      end
      if (cmd.create_take) begin
         res_status_ff  <= STATUS_OK;
         res_thread_ff  <= THREAD_W'(create_idx_ff);
         res_outcome_ff <= OUTCOME_IDLE;
      end
      if (cmd.scan_pick) begin
         res_status_ff  <= STATUS_OK;
         res_thread_ff  <= chk_thread;
         res_outcome_ff <= (chk_thread == cur) ? OUTCOME_SAME : OUTCOME_SWITCH;
      end
      if (cmd.scan_miss) begin
         res_status_ff  <= STATUS_OK;
         res_thread_ff  <= NO_THREAD;
         res_outcome_ff <= OUTCOME_IDLE;
      end
      if (cmd.emit) begin
         rsp_status_ff  <= res_status_ff;
         rsp_thread_ff  <= res_thread_ff;
         rsp_outcome_ff <= res_outcome_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_thread = rsp_thread_ff;
   assign rsp_outcome       = rsp_outcome_ff;

   a_create_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.create_take |=> slot_valid_ff[$past(create_idx_ff)])
      else $error("created slot is not marked valid");

   a_destroy_clears_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.do_destroy |=> !slot_valid_ff[$past(tid_slot)])
      else $error("destroyed slot is still valid");

   a_pick_moves_pointer: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_pick |=> pick_ptr_ff == next_slot($past(chk_addr_ff)))
      else $error("pick pointer did not move past the picked slot");

   a_pick_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_pick |-> scan_hit && chk_v_ff)
      else $error("slot picked without a runnable hit");

   a_no_step_past_end: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> issued_ff < COUNT_W'(MAX_THREADS))
      else $error("scan issued more reads than there are slots");

endmodule

### hdl/rrts_controller.sv
// Scheduler controller: sequences each operation over the datapath.
module rrts_controller import rrts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.func)
               FUNC_CREATE: begin
                  cmd.create_init = 1'b1;
                  state_in        = S_CREATE;
               end
               FUNC_DESTROY: begin
                  cmd.do_destroy = sts.tid_in_range;
                  cmd.res_ok     = 1'b1;
                  state_in       = S_RESPOND;
               end
               FUNC_SET_STATE: begin
                  // A free slot keeps its state.
                  cmd.do_set_state = sts.tid_in_range && sts.tid_valid;
                  cmd.res_ok       = 1'b1;
                  state_in         = S_RESPOND;
               end
               FUNC_RESCHEDULE: begin
                  if (!sts.cpu_ok) begin
                     cmd.res_bad_cpu = 1'b1;
                     state_in        = S_RESPOND;
                  end else begin
                     cmd.scan_init = 1'b1;
                     if (sts.release_needed) begin
                        cmd.rel_read = 1'b1;
                        state_in     = S_RELEASE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               end
            endcase
         end
         S_RELEASE: begin
            cmd.rel_write = sts.owner_match;
            state_in      = S_SCAN;
         end
         S_CREATE: begin
            if (sts.create_free) begin
               cmd.create_take = 1'b1;
               state_in        = S_RESPOND;
            end else if (sts.create_last) begin
               cmd.res_full = 1'b1;
               state_in     = S_RESPOND;
            end else begin
               cmd.create_next = 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.scan_hit) begin
               cmd.scan_pick = 1'b1;
               state_in      = S_RESPOND;
            end else if (sts.scan_exhausted) begin
               cmd.scan_miss = 1'b1;
               state_in      = S_RESPOND;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RESPOND: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hdl/round_robin_thread_scheduler_unit.sv
// Top level of the round-robin thread scheduler: controller, datapath and channel wiring.
//
//   channel   direction  handshake            beat contents
//   req_ch    in         valid/ready          func, slot_id, state_code, cpu, keep_owner
//   rsp_ch    out        valid/ready          status, result_thread, outcome
//   csr_*     in         write enable only    register index, write data
//
// One operation is in flight at a time. Destroy and set state pass through the dispatch
// state to the result register; create searches from slot zero for the lowest free slot,
// as the slot search walks the valid bits one a cycle.
// Reschedule reads the table RAM one slot a cycle from the pick pointer, after a release
// step for the current thread where one is needed.
// Reset is synchronous and needs no clearing pass. A stalled result waits in the
// output register while the next request beat is already accepted.
module round_robin_thread_scheduler_unit import rrts_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rrts_req_if.sink               req_ch,
   rrts_rsp_if.source             rsp_ch,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   rrts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrts_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_func          (req_ch.func),
      .req_slot_id       (req_ch.slot_id),
      .req_state_code    (req_ch.state_code),
      .req_cpu           (req_ch.cpu),
      .req_keep_owner    (req_ch.keep_owner),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_result_thread (rsp_ch.result_thread),
      .rsp_outcome       (rsp_ch.outcome),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

### tb/sv/round_robin_thread_scheduler_unit_tb.sv
// Self-checking testbench of the round-robin thread scheduler unit.
module round_robin_thread_scheduler_unit_tb import rrts_pkg::*; ();

   // Owner code of a slot that no processor holds.
   localparam logic [OWNER_W-1:0] HOLDER_NONE = OWNER_W'(MAX_CPUS);

   typedef struct packed {
      status_type          status;
      logic [THREAD_W-1:0] thread;
      outcome_type         outcome;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rrts_req_if req_if();
   rrts_rsp_if rsp_if();

   round_robin_thread_scheduler_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predicted thread table, processor bindings and registers.
   logic                   slot_live   [MAX_THREADS];
   logic [CODE_W-1:0]      slot_code   [MAX_THREADS];
   logic [OWNER_W-1:0]     slot_holder [MAX_THREADS];
   logic [THREAD_W-1:0]    running     [MAX_CPUS];
   logic [SLOT_W-1:0]      rotor;
   logic [CPU_COUNT_W-1:0] cpus_served;
   logic [CODE_W-1:0]      ready_code;

   sched_result_type awaited_results[$];
   int  errors = 0;
   int  stall_left = 0;
   bit  req_gaps_on = 1'b0;
   bit  rsp_stalls_on = 1'b0;

   function automatic void clear_table_model();
      for (int i = 0; i < MAX_THREADS; i++) begin
         slot_live[i]   = 1'b0;
         slot_code[i]   = '0;
         slot_holder[i] = HOLDER_NONE;
      end
      for (int c = 0; c < MAX_CPUS; c++) begin
         running[c] = NO_THREAD;
      end
      rotor       = '0;
      cpus_served = CPU_COUNT_RESET;
      ready_code  = RUNNABLE_RESET;
   endfunction

   function automatic int live_count();
      int n;
      n = 0;
      for (int i = 0; i < MAX_THREADS; i++) begin
         if (slot_live[i]) n++;
      end
      return n;
   endfunction

   // Circular search from the rotor; the rotor moves past every slot looked at,
   // the picked one included, and wraps naturally at the table size.
   function automatic logic [THREAD_W-1:0] scan_runnable();
      logic [THREAD_W-1:0] found;
      logic [SLOT_W-1:0]   p;
      found = NO_THREAD;
      for (int n = 0; n <= MAX_THREADS && found == NO_THREAD; n++) begin
         p     = rotor;
         rotor = rotor + 1'b1;
         if (slot_live[p] && slot_code[p] == ready_code && slot_holder[p] == HOLDER_NONE) begin
            found = {1'b0, p};
         end
      end
      return found;
   endfunction

   function automatic sched_result_type schedule_step(func_type op, logic [THREAD_W-1:0] tid,
         logic [CODE_W-1:0] code, logic [CPU_W-1:0] cpu, logic keep);
      sched_result_type r;
      logic [THREAD_W-1:0] cur;
      logic [THREAD_W-1:0] nxt;
      bit placed;
      r.status  = STATUS_OK;
      r.thread  = NO_THREAD;
      r.outcome = OUTCOME_IDLE;
      placed    = 1'b0;
      case (op)
         FUNC_CREATE: begin
            r.status = STATUS_FULL;
            for (int i = 0; i < MAX_THREADS; i++) begin
               if (!placed && !slot_live[i]) begin
                  placed         = 1'b1;
                  slot_live[i]   = 1'b1;
                  slot_code[i]   = '0;
                  slot_holder[i] = HOLDER_NONE;
                  r.status       = STATUS_OK;
                  r.thread       = THREAD_W'(i);
               end
            end
         end
         FUNC_DESTROY: begin
            if (tid < MAX_THREADS) begin
               slot_live[tid[SLOT_W-1:0]]   = 1'b0;
               slot_code[tid[SLOT_W-1:0]]   = '0;
               slot_holder[tid[SLOT_W-1:0]] = HOLDER_NONE;
            end
         end
         FUNC_SET_STATE: begin
            if (tid < MAX_THREADS && slot_live[tid[SLOT_W-1:0]]) begin
               slot_code[tid[SLOT_W-1:0]] = code;
            end
         end
         default: begin
            if (cpu >= cpus_served) begin
               r.status = STATUS_BAD_CPU;
            end else begin
               cur = running[cpu];
               // A destroyed current thread is not released: the slot is no longer live.
               if (!keep && cur < MAX_THREADS && slot_live[cur[SLOT_W-1:0]] &&
                   slot_holder[cur[SLOT_W-1:0]] == {1'b0, cpu}) begin
                  slot_holder[cur[SLOT_W-1:0]] = HOLDER_NONE;
               end
               nxt          = scan_runnable();
               running[cpu] = nxt;
               if (nxt != NO_THREAD) begin
                  slot_holder[nxt[SLOT_W-1:0]] = {1'b0, cpu};
                  r.thread  = nxt;
                  r.outcome = (nxt == cur) ? OUTCOME_SAME : OUTCOME_SWITCH;
               end
            end
         end
      endcase
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length(bit enabled);
      int roll;
      roll = $urandom_range(99);
      if (!enabled || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic send_op(func_type op, logic [THREAD_W-1:0] tid, logic [CODE_W-1:0] code,
         logic [CPU_W-1:0] cpu, logic keep);
      int gap;
      gap = gap_length(req_gaps_on);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= op;
      req_if.slot_id    <= tid;
      req_if.state_code <= code;
      req_if.cpu        <= cpu;
      req_if.keep_owner <= keep;
      do @(posedge clock); while (!req_if.ready);
      awaited_results.push_back(schedule_step(op, tid, code, cpu, keep));
   endtask

   // Lets every outstanding result arrive, leaving the block idle.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_CPU_COUNT) begin
         cpus_served = value;
      end else begin
         ready_code = value;
      end
   endtask

   function automatic logic [CPU_W-1:0] pick_cpu();
      int top;
      top = (cpus_served > MAX_CPUS) ? MAX_CPUS : cpus_served;
      if (top == 0 || $urandom_range(99) < 15) return CPU_W'($urandom_range(MAX_CPUS - 1));
      return CPU_W'($urandom_range(top - 1));
   endfunction

   // Mostly a live slot, sometimes a free one or a number past the table.
   function automatic logic [THREAD_W-1:0] pick_target();
      logic [THREAD_W-1:0] t;
      if ($urandom_range(99) < 8) return THREAD_W'($urandom_range(MAX_THREADS, 127));
      t = THREAD_W'($urandom_range(MAX_THREADS - 1));
      for (int k = 0; k < 6 && !slot_live[t[SLOT_W-1:0]]; k++) begin
         t = THREAD_W'($urandom_range(MAX_THREADS - 1));
      end
      return t;
   endfunction

   task automatic random_op(int create_pct);
      int roll;
      logic [CODE_W-1:0] code;
      roll = $urandom_range(99);
      code = ($urandom_range(99) < 60) ? ready_code : CODE_W'($urandom_range(15));
      if (roll < create_pct) begin
         // The unused fields of a create carry noise.
         send_op(FUNC_CREATE, THREAD_W'($urandom_range(127)), code, CPU_W'($urandom_range(7)),
                 1'($urandom_range(1)));
      end else begin
         roll = $urandom_range(99);
         if (roll < 18) begin
            send_op(FUNC_DESTROY, pick_target(), code, pick_cpu(), 1'($urandom_range(1)));
         end else if (roll < 52) begin
            send_op(FUNC_SET_STATE, pick_target(), code, pick_cpu(), 1'($urandom_range(1)));
         end else begin
            send_op(FUNC_RESCHEDULE, pick_target(), code, pick_cpu(),
                    1'($urandom_range(99) < 30));
         end
      end
   endtask

   // Result consumer with random back-pressure.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(99) < 30) begin
         stall_left   <= ($urandom_range(99) < 90) ? $urandom_range(0, 2) : $urandom_range(5, 30);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic report(string what, int want, int got);
      errors++;
      if (errors <= 100) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      sched_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_results.size() == 0) begin
            report("unexpected beat, status", -1, rsp_if.status);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_if.status !== want.status) report("status", want.status, rsp_if.status);
            if (rsp_if.result_thread !== want.thread) begin
               report("result_thread", want.thread, rsp_if.result_thread);
            end
            if (rsp_if.outcome !== want.outcome) report("outcome", want.outcome, rsp_if.outcome);
         end
      end
   end

   // Register reset values; every operation, release, keep, stale current thread.
   task automatic test_reset_defaults();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_SET_STATE, 7'd0, 4'd1, '0, 1'b0);
      send_op(FUNC_SET_STATE, 7'd2, 4'd1, '0, 1'b0);
      // Writing the state of a free slot has no effect.
      send_op(FUNC_SET_STATE, 7'd10, 4'd1, '0, 1'b0);
      send_op(FUNC_SET_STATE, NO_THREAD, 4'd15, '0, 1'b0);
      send_op(FUNC_DESTROY, 7'd127, '0, '0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd0, 1'b1);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd1, 1'b0);
      send_op(FUNC_RESCHEDULE, 7'd127, 4'd15, 3'd7, 1'b1);
      send_op(FUNC_DESTROY, 7'd2, '0, '0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd0, 1'b0);
      send_op(FUNC_DESTROY, 7'd0, '0, '0, 1'b0);
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_SET_STATE, 7'd63, 4'd15, '0, 1'b0);
      send_op(FUNC_SET_STATE, 7'd0, 4'd15, '0, 1'b0);
      send_op(FUNC_SET_STATE, 7'd1, 4'd1, '0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd0, 1'b0);
      send_op(FUNC_SET_STATE, 7'd1, 4'd0, '0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd0, 1'b0);
      settle();
   endtask

   // All processors served and the register extremes of the runnable code.
   task automatic test_register_extremes();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      write_reg(CSR_CPU_COUNT, 4'd8);
      write_reg(CSR_RUNNABLE, 4'd0);
      // With runnable code zero a fresh thread can run at once.
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd7, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd6, 1'b1);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd7, 1'b1);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd3, 1'b0);
      settle();
      write_reg(CSR_RUNNABLE, 4'd15);
      send_op(FUNC_SET_STATE, 7'd1, 4'd15, '0, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd7, 1'b0);
      send_op(FUNC_RESCHEDULE, '0, '0, 3'd5, 1'b0);
      settle();
   endtask

   // Fill every slot, overflow, then free a few and reuse the lowest ones.
   task automatic test_table_full();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      write_reg(CSR_RUNNABLE, 4'd1);
      while (live_count() < MAX_THREADS) begin
         if ($urandom_range(99) < 80) begin
            send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
         end else begin
            send_op(FUNC_SET_STATE, pick_target(), 4'd1, '0, 1'b0);
         end
      end
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      repeat (8) send_op(FUNC_RESCHEDULE, '0, '0, pick_cpu(), 1'($urandom_range(1)));
      repeat (5) send_op(FUNC_DESTROY, THREAD_W'($urandom_range(MAX_THREADS - 1)), '0, '0, 1'b0);
      repeat (3) send_op(FUNC_CREATE, '0, '0, '0, 1'b0);
      settle();
   endtask

   // Random traffic across several register settings and idling patterns.
   task automatic test_random_traffic();
      logic [CPU_COUNT_W-1:0] counts [5];
      logic [CODE_W-1:0]      codes  [5];
      counts = '{4'd8, 4'd1, 4'd5, 4'd8, CPU_COUNT_W'($urandom_range(1, MAX_CPUS))};
      codes  = '{4'd1, 4'd0, 4'd15, CODE_W'($urandom_range(15)), CODE_W'($urandom_range(15))};
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_CPU_COUNT, counts[ph]);
         write_reg(CSR_RUNNABLE, codes[ph]);
         req_gaps_on   = (ph != 0);
         rsp_stalls_on = (ph != 1);
         repeat (120) random_op((live_count() < 8) ? 45 : 12);
         settle();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_CPU_COUNT;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.func       <= FUNC_CREATE;
      req_if.slot_id    <= '0;
      req_if.state_code <= '0;
      req_if.cpu        <= '0;
      req_if.keep_owner <= 1'b0;
      clear_table_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_table_full();
      test_random_traffic();

      repeat (80) @(posedge clock);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
